// File: src/kmv_pkg.sv
// Package for the k-minimum-values distinct sketch.
// Holds shared constants and the sequencer state type; depends on nothing.
`timescale 1ns / 1ps
package kmv_pkg;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned EST_W   = 38;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [EST_W-1:0]   EST_MAX   = '1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;
endpackage

// File: src/kmv_if.sv
// Valid/ready stream interfaces for the sketch input and result channels.
// Depends on kmv_pkg for field widths.
`timescale 1ns / 1ps
interface kmv_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [31:0] hash_value;
  modport source (output valid, restart, hash_value, input ready);
  modport sink   (input valid, restart, hash_value, output ready);
endinterface

interface kmv_out_if;
  logic                        valid;
  logic                        ready;
  logic                        was_held;
  logic [kmv_pkg::COUNT_W-1:0] entry_count;
  logic [6:0]                  held_entries;
  logic [31:0]                 largest_kept;
  logic [kmv_pkg::EST_W-1:0]   distinct_estimate;
  modport source (output valid, was_held, entry_count, held_entries, largest_kept,
                  distinct_estimate, input ready);
  modport sink   (input valid, was_held, entry_count, held_entries, largest_kept,
                  distinct_estimate, output ready);
endinterface

// File: src/kmv_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module kmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One optional write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: src/kmv_divider.sv
// Restoring divider, one quotient bit per cycle, saturating result.
// Depends on kmv_pkg.
`timescale 1ns / 1ps
module kmv_divider #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output logic                      done,
  output logic [kmv_pkg::EST_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  // Shift-subtract loop over the numerator bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        q    <= num;
        d    <= den;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate the quotient to the estimate width.
  always_comb begin
    if (NUM_W > kmv_pkg::EST_W && |(q >> kmv_pkg::EST_W)) quot = kmv_pkg::EST_MAX;
    else quot = kmv_pkg::EST_W'(q);
  end
endmodule

// File: src/kmv_distinct_sketch_core.sv
// Top level of the k-minimum-values distinct sketch.
// Depends on kmv_pkg, kmv_if, kmv_ram and kmv_divider.
//
// Use: one hash enters per transfer on the input channel (restart, hash_value)
// and produces exactly one result transfer on the output channel.
// The sorted store lives in two RAMs (hashes, counts). A sequencer scans the
// held entries one at a time (address, RAM read, compare) to find a match or
// the insert position. It then shifts entries up (address, RAM read, write)
// to open the slot, reads the largest entry and runs the divider, one
// quotient bit per cycle (HASH_BITS+NW steps, 39 at defaults).
// The divider is not started when at most one entry is held or the largest
// entry is zero.
// sketch_size is written through cfg_we/cfg_data; the user must write it only
// while idle, as the block itself does not enforce this.
// The block takes one item at a time; ready is low while an item is in work.
// The result sits in an output register until the receiver takes it; a stall
// simply holds it and the next item waits.
// Reset empties the sketch (held count zero) and sets sketch_size to 64.
`timescale 1ns / 1ps
module kmv_distinct_sketch_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int HASH_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  kmv_in_if.sink      in_ch,
  kmv_out_if.source   out_ch
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam int NUMW = HASH_BITS + NW;

  logic [6:0]   sketch_size;
  kmv_pkg::state_t state;
  logic [NW-1:0] held;
  logic [NW-1:0] k_eff;
  logic [NW-1:0] pos;
  logic [NW-1:0] ptr;
  logic [HASH_BITS-1:0] h;
  logic          found;
  logic          phase;
  logic [1:0]    sub;
  logic          we;
  logic [AW-1:0] addr;
  logic [HASH_BITS-1:0] wh, rh;
  logic [kmv_pkg::COUNT_W-1:0] wc, rc;
  logic [kmv_pkg::COUNT_W-1:0] cnt_out;
  logic [HASH_BITS-1:0] largest;
  logic          div_start, div_done;
  logic [kmv_pkg::EST_W-1:0] quot;
  logic [NW-1:0] n_trim;

  // Effective k, clamped to 1..MAX_ENTRIES.
  always_comb begin
    if (sketch_size == '0) k_eff = NW'(1);
    else if (32'(sketch_size) > MAX_ENTRIES) k_eff = NW'(MAX_ENTRIES);
    else k_eff = NW'(sketch_size);
  end

  assign n_trim = (held > k_eff) ? k_eff : held;

  kmv_ram #(.WIDTH(HASH_BITS), .DEPTH(MAX_ENTRIES)) u_hash (
    .clk(clk), .we(we), .addr(addr), .wdata(wh), .rdata(rh));
  kmv_ram #(.WIDTH(kmv_pkg::COUNT_W), .DEPTH(MAX_ENTRIES)) u_count (
    .clk(clk), .we(we), .addr(addr), .wdata(wc), .rdata(rc));

  kmv_divider #(.NUM_W(NUMW), .DEN_W(HASH_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({NW'(held - NW'(1)), {HASH_BITS{1'b0}}}), .den(largest),
    .done(div_done), .quot(quot));

  assign in_ch.ready = (state == kmv_pkg::ST_IDLE) && !out_ch.valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) sketch_size <= 7'd64;
    else if (cfg_we) sketch_size <= cfg_data;
  end

  // Sequencer. Scan: sub 0 issue read at ptr, sub 2 compare, sub 3 decide insertion.
  // Shift: sub 0 read ptr-1, sub 2 write ptr. Then finalize and divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kmv_pkg::ST_IDLE;
      held         <= '0;
      out_ch.valid <= 1'b0;
      we           <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      we        <= 1'b0;
      div_start <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        kmv_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            h     <= HASH_BITS'(in_ch.hash_value);
            if (in_ch.restart) held <= '0;
            found <= 1'b0;
            ptr   <= '0;
            sub   <= 2'd0;
            state <= kmv_pkg::ST_SCAN;
          end
        end
        kmv_pkg::ST_SCAN: begin
          if (sub == 2'd0) begin
            if (ptr >= held) begin
              // No match: insert position is ptr == held.
              pos <= ptr;
              sub <= 2'd3;
            end else begin
              addr <= AW'(ptr);
              sub  <= 2'd1;
            end
          end else if (sub == 2'd1) begin
            sub <= 2'd2;
          end else if (sub == 2'd2) begin
            if (rh == h) begin
              found <= 1'b1;
              pos   <= ptr;
              addr  <= AW'(ptr);
              wh    <= h;
              wc    <= (rc == kmv_pkg::COUNT_MAX) ? rc : rc + 1'b1;
              // A match that falls beyond the trimmed size reports zero.
              if (ptr >= n_trim) cnt_out <= '0;
              else cnt_out <= (rc == kmv_pkg::COUNT_MAX) ? rc : rc + 1'b1;
              we    <= 1'b1;
              held  <= n_trim;
              phase <= 1'b0;
              state <= kmv_pkg::ST_DIV;
            end else if (rh > h) begin
              pos <= ptr;
              sub <= 2'd3;
            end else begin
              ptr <= ptr + 1'b1;
              sub <= 2'd0;
            end
          end else begin
            // Decide insertion against the trimmed count.
            if (n_trim < k_eff) begin
              held    <= n_trim + 1'b1;
              ptr     <= n_trim;
              cnt_out <= 16'd1;
              sub     <= 2'd0;
              state   <= kmv_pkg::ST_SHIFT;
            end else if (pos < n_trim) begin
              held    <= n_trim;
              ptr     <= n_trim - 1'b1;
              cnt_out <= 16'd1;
              sub     <= 2'd0;
              state   <= kmv_pkg::ST_SHIFT;
            end else begin
              held    <= n_trim;
              cnt_out <= '0;
              phase   <= 1'b0;
              state   <= kmv_pkg::ST_DIV;
            end
          end
        end
        kmv_pkg::ST_SHIFT: begin
          if (ptr == pos) begin
            addr  <= AW'(pos);
            wh    <= h;
            wc    <= 16'd1;
            we    <= 1'b1;
            phase <= 1'b0;
            state <= kmv_pkg::ST_DIV;
          end else if (sub == 2'd0) begin
            addr <= AW'(ptr - 1'b1);
            sub  <= 2'd1;
          end else if (sub == 2'd1) begin
            sub <= 2'd2;
          end else begin
            addr <= AW'(ptr);
            wh   <= rh;
            wc   <= rc;
            we   <= 1'b1;
            ptr  <= ptr - 1'b1;
            sub  <= 2'd0;
          end
        end
        kmv_pkg::ST_DIV: begin
          // Phase 0: read the largest entry; then start the divider or skip it.
          if (!phase) begin
            if (!we) begin
              addr  <= AW'(held - 1'b1);
              phase <= 1'b1;
              sub   <= 2'd0;
            end
          end else if (sub == 2'd0) begin
            sub <= 2'd1;
          end else if (sub == 2'd1) begin
            largest <= (held == '0) ? '0 : rh;
            sub     <= 2'd2;
            if (held > NW'(1) && rh != '0) div_start <= 1'b1;
            else state <= kmv_pkg::ST_OUT;
          end else if (div_done) begin
            state <= kmv_pkg::ST_OUT;
          end
        end
        kmv_pkg::ST_OUT: begin
          out_ch.valid        <= 1'b1;
          out_ch.was_held     <= found;
          out_ch.entry_count  <= cnt_out;
          out_ch.held_entries <= 7'(held);
          out_ch.largest_kept <= 32'(largest);
          if (held <= NW'(1)) out_ch.distinct_estimate <= '0;
          else if (largest == '0) out_ch.distinct_estimate <= kmv_pkg::EST_MAX;
          else out_ch.distinct_estimate <= quot;
          state <= kmv_pkg::ST_IDLE;
        end
        default: state <= kmv_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

// File: dv/kmv_distinct_sketch_core_test.sv
// Self-checking testbench for kmv_distinct_sketch_core.
// Drives hashes and restarts over the input channel, predicts every result
// with a behavioral copy of the sorted sketch, and compares field by field.
`timescale 1ns / 1ps
module kmv_distinct_sketch_core_test;

  localparam int MAXN = 64;
  localparam longint unsigned LIMIT = 3000000;

  typedef struct packed {
    logic                      was_held;
    logic [15:0]               entry_count;
    logic [6:0]                held_entries;
    logic [31:0]               largest_kept;
    logic [kmv_pkg::EST_W-1:0] distinct_estimate;
  } sketch_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  kmv_in_if  in_ch ();
  kmv_out_if out_ch ();

  kmv_distinct_sketch_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: the sorted store and the configured size.
  logic [31:0] sk_hash [MAXN+1];
  logic [15:0] sk_cnt  [MAXN+1];
  int unsigned sk_held;
  logic [6:0]  sk_size;

  sketch_result_t pending_results[$];
  int  errors = 0;
  bit  no_idle;
  bit  hold_sink;
  int  hold_cycles;
  longint unsigned cycle_count = 0;

  // Insert a hash in ascending order with count one.
  task automatic sketch_insert(input logic [31:0] h);
    int unsigned pos;
    pos = 0;
    while (pos < sk_held && sk_hash[pos] < h) pos++;
    for (int unsigned i = sk_held; i > pos; i--) begin
      sk_hash[i] = sk_hash[i-1];
      sk_cnt[i]  = sk_cnt[i-1];
    end
    sk_hash[pos] = h;
    sk_cnt[pos]  = 16'd1;
    sk_held++;
  endtask

  // Work out the result one item causes and update the predicted sketch.
  task automatic predict_sketch(input logic rs, input logic [31:0] h,
                                output sketch_result_t r);
    int unsigned k, idx;
    bit found;
    logic [15:0] cnt_out;
    logic [31:0] largest;
    logic [70:0] num, est;
    k = (sk_size == 0) ? 1 : (sk_size > MAXN) ? MAXN : sk_size;
    found = 0;
    idx = 0;
    cnt_out = '0;
    largest = '0;
    est = '0;
    if (rs) sk_held = 0;
    for (int unsigned i = 0; i < sk_held; i++)
      if (!found && sk_hash[i] == h) begin
        found = 1;
        idx = i;
      end
    if (found) begin
      if (sk_cnt[idx] != kmv_pkg::COUNT_MAX) sk_cnt[idx]++;
      if (sk_held > k) sk_held = k;
      if (idx < sk_held) cnt_out = sk_cnt[idx];
    end else begin
      if (sk_held > k) sk_held = k;
      if (sk_held < k) begin
        sketch_insert(h);
        cnt_out = 16'd1;
      end else if (sk_held > 0 && h < sk_hash[sk_held-1]) begin
        sk_held--;
        sketch_insert(h);
        cnt_out = 16'd1;
      end
    end
    if (sk_held > 0) largest = sk_hash[sk_held-1];
    if (sk_held > 1) begin
      if (largest == 0) est = kmv_pkg::EST_MAX;
      else begin
        num = 71'(sk_held - 1) << 32;
        est = num / largest;
        if (est > kmv_pkg::EST_MAX) est = kmv_pkg::EST_MAX;
      end
    end
    r.was_held = found;
    r.entry_count = cnt_out;
    r.held_entries = 7'(sk_held);
    r.largest_kept = largest;
    r.distinct_estimate = est[kmv_pkg::EST_W-1:0];
  endtask

  // Offer one item, with a random gap first unless no_idle is set, and predict it on transfer.
  // Ready only changes at rising edges, so it is sampled at the falling edge.
  task automatic send_hash(input logic rs, input logic [31:0] h);
    sketch_result_t r;
    while (!no_idle && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= rs;
    in_ch.hash_value <= h;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    predict_sketch(rs, h, r);
    pending_results = {pending_results, r};
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_size(input logic [6:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sk_size = v;
  endtask

  // Receiver: random stalls, or a long counted hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_sink && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (!hold_sink) hold_cycles <= 0;
      out_ch.ready <= no_idle || ($urandom_range(99) >= 36);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    sketch_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.was_held !== e.was_held) begin
          $error("was_held exp %0h got %0h", e.was_held, out_ch.was_held); errors++;
        end
        if (out_ch.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_ch.entry_count);
          errors++;
        end
        if (out_ch.held_entries !== e.held_entries) begin
          $error("held_entries exp %0d got %0d", e.held_entries, out_ch.held_entries);
          errors++;
        end
        if (out_ch.largest_kept !== e.largest_kept) begin
          $error("largest_kept exp %0h got %0h", e.largest_kept, out_ch.largest_kept);
          errors++;
        end
        if (out_ch.distinct_estimate !== e.distinct_estimate) begin
          $error("distinct_estimate exp %0h got %0h", e.distinct_estimate,
                 out_ch.distinct_estimate);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("** kmv_distinct_sketch_core: FAILED **");
      $finish;
    end
  end

  // Directed: extremes, few entries, zero largest, size out of range.
  task automatic test_directed();
    send_hash(1'b1, 32'h0);
    send_hash(1'b0, 32'h0);
    send_hash(1'b0, 32'hFFFF_FFFF);
    send_hash(1'b1, 32'h0);
    send_hash(1'b0, 32'h0);
    send_hash(1'b0, 32'h1);
    send_hash(1'b1, 32'h1);
    send_hash(1'b0, 32'h2);
    send_hash(1'b0, 32'h3);
    send_hash(1'b0, 32'hAAAA_5555);
    send_hash(1'b0, 32'h5555_AAAA);
    write_size(7'd0);
    send_hash(1'b0, 32'h9);
    send_hash(1'b0, 32'h1);
    send_hash(1'b0, 32'h9);
    write_size(7'd127);
    for (int i = 0; i < 4; i++) send_hash(1'b0, 32'h100 + i);
    write_size(7'd2);
    send_hash(1'b0, 32'h103);
    send_hash(1'b0, 32'h102);
    send_hash(1'b0, 32'h1);
  endtask

  // Repeated hash on a single-entry sketch, back to back.
  task automatic test_repeat_counts();
    write_size(7'd1);
    no_idle = 1;
    send_hash(1'b1, 32'h1234_5678);
    for (int i = 0; i < 30; i++) send_hash(1'b0, 32'h1234_5678);
    send_hash(1'b0, 32'h0000_0001);
    no_idle = 0;
  endtask

  // Random streams over several sizes with repeats and returning hashes.
  task automatic test_random_streams();
    logic [6:0] sizes [6] = '{7'd64, 7'd1, 7'd5, 7'd16, 7'd64, 7'd3};
    logic [31:0] pool [16];
    logic [31:0] h;
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      for (int j = 0; j < 16; j++) pool[j] = $urandom();
      for (int j = 0; j < 200; j++) begin
        if (p == 4 && j == 100) no_idle = 1;
        if (p == 4 && j == 180) no_idle = 0;
        case ($urandom_range(3))
          0: h = $urandom();
          1: h = $urandom_range(40);
          default: h = pool[$urandom_range(15)];
        endcase
        send_hash($urandom_range(60) == 0, h);
      end
    end
  endtask

  // Receiver holds off while items keep coming; then sender waits out results.
  task automatic test_backpressure();
    write_size(7'd8);
    hold_sink = 1;
    for (int j = 0; j < 20; j++) send_hash(1'b0, $urandom_range(30));
    hold_sink = 0;
    drain_results();
    for (int j = 0; j < 20; j++) send_hash(1'b0, $urandom());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.hash_value = '0;
    no_idle = 0;
    hold_sink = 0;
    sk_held = 0;
    sk_size = 7'd64;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_streams();
    test_backpressure();
    test_repeat_counts();
    drain_results();
    if (errors == 0 && pending_results.size() == 0)
      $display("** kmv_distinct_sketch_core: PASSED **");
    else
      $display("** kmv_distinct_sketch_core: FAILED **");
    $finish;
  end
endmodule

// File: kmv_distinct_sketch_core.f
src/kmv_pkg.sv
src/kmv_if.sv
src/kmv_ram.sv
src/kmv_divider.sv
src/kmv_distinct_sketch_core.sv
dv/kmv_distinct_sketch_core_test.sv
